>>> hw/rtl/pvo_pkg.sv
// ----------------------------------------------------------------------------
// pvo_pkg: shared constants of the planar odometry block
// Angle table, fixed-point scale constants and field widths.
// ----------------------------------------------------------------------------
package pvo_pkg;

    localparam int ANG_W   = 32;   // binary angle, full turn is 2**32
    localparam int CRD_W   = 34;   // CORDIC datapath, Q1.30 with headroom
    localparam int VEL_W   = 16;
    localparam int US_W    = 20;
    localparam int POS_W   = 32;
    localparam int QUAT_W  = 16;

    // Gain-compensated CORDIC start value, Q1.30.
    localparam logic signed [CRD_W-1:0] GAIN_Q30 = 34'sd652032874;
    // Heading step is turn_rate * elapsed_us * TURN_SCALE / 2**TURN_SHIFT.
    localparam logic [25:0] TURN_SCALE = 26'd44798134;
    localparam int          TURN_SHIFT = 28;
    // Position step divides the Q.14 world velocity times microseconds by this.
    localparam logic [29:0] POS_DIVISOR = 30'd1024000000;

    // Item kinds carried in the input tuser.
    localparam logic KIND_MOTION = 1'b0;
    localparam logic KIND_RESET  = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] REG_INIT_X       = 2'd0;
    localparam logic [1:0] REG_INIT_Y       = 2'd1;
    localparam logic [1:0] REG_INIT_HEADING = 2'd2;

    // arctan(2**-i) in binary-angle units.
    function automatic logic [ANG_W-1:0] atan_turn(input logic [4:0] i);
        logic [ANG_W-1:0] a;
        case (i)
            5'd0:  a = 32'h20000000;
            5'd1:  a = 32'h12E4051E;
            5'd2:  a = 32'h09FB385B;
            5'd3:  a = 32'h051111D4;
            5'd4:  a = 32'h028B0D43;
            5'd5:  a = 32'h0145D7E1;
            5'd6:  a = 32'h00A2F61E;
            5'd7:  a = 32'h00517C55;
            5'd8:  a = 32'h0028BE53;
            5'd9:  a = 32'h00145F2F;
            5'd10: a = 32'h000A2F98;
            5'd11: a = 32'h000517CC;
            5'd12: a = 32'h00028BE6;
            5'd13: a = 32'h000145F3;
            5'd14: a = 32'h0000A2FA;
            5'd15: a = 32'h0000517D;
            5'd16: a = 32'h000028BE;
            5'd17: a = 32'h0000145F;
            5'd18: a = 32'h00000A30;
            5'd19: a = 32'h00000518;
            5'd20: a = 32'h0000028C;
            5'd21: a = 32'h00000146;
            5'd22: a = 32'h000000A3;
            5'd23: a = 32'h00000051;
            5'd24: a = 32'h00000029;
            5'd25: a = 32'h00000014;
            5'd26: a = 32'h0000000A;
            5'd27: a = 32'h00000005;
            5'd28: a = 32'h00000003;
            5'd29: a = 32'h00000001;
            5'd30: a = 32'h00000001;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

endpackage

>>> hw/rtl/planar_velocity_odometry_unit.sv
// ----------------------------------------------------------------------------
// planar_velocity_odometry_unit: 2D dead-reckoning odometry
// A motion item, once its input beat is accepted, runs CORDIC on the heading,
// bit-serial rotation of the velocity, a bit-serial time multiply, bit-serial
// division by the position scale with the heading step multiply alongside, a
// pose and heading update, then CORDIC on half the heading, and gives its
// result beat. A reset item runs CORDIC on half the heading and gives its first
// beat, then clears pose and heading and gives its second beat.
// One item at a time; the next is taken while the last result beat waits.
// Synchronous active-low reset clears pose, heading and all handshakes.
// ----------------------------------------------------------------------------
module planar_velocity_odometry_unit #(
    parameter int CORDIC_STEPS = 20
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [71:0]  s_tdata,   // vel_x, vel_y, turn_rate, elapsed_us, zero pad
    input  logic [0:0]   s_tuser,   // kind
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // out_x, out_y, out_heading, quat_z, quat_w
    output logic [0:0]   m_tuser,   // is_reset_report
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    import pvo_pkg::*;

    localparam int ACC_W = 50;   // rotated velocity before rounding
    localparam int WV_W  = 34;   // world velocity, Q.14
    localparam int PM_W  = 54;   // world velocity times microseconds
    localparam int TP_W  = 37;   // turn rate times microseconds
    localparam int TA_W  = 64;   // turn product times scale

    typedef enum logic [3:0] {
        S_IDLE, S_HGO, S_HWAIT, S_VMUL, S_VRND, S_TMUL, S_DIV, S_UPD,
        S_QGO, S_QWAIT, S_EMIT
    } state_t;

    state_t state_reg;
    logic   kind_reg, second_reg;
    logic [5:0] cnt_reg;
    logic [VEL_W-1:0] vx_reg, vy_reg;
    logic signed [VEL_W-1:0] tr_reg;
    logic [US_W-1:0] us_reg;

    logic signed [POS_W-1:0] pose_x_reg, pose_y_reg;
    logic [ANG_W-1:0] heading_reg;

    logic signed [ACC_W-1:0] mc_reg, ms_reg, accx_reg, accy_reg;
    logic signed [PM_W-1:0]  mwx_reg, mwy_reg, pacx_reg, pacy_reg;
    logic signed [TP_W-1:0]  mtr_reg, ptr_reg;
    logic signed [TA_W-1:0]  mt_reg, acct_reg;
    logic [25:0] kc_reg;
    logic [PM_W-1:0] dvx_reg, dvy_reg;
    logic [29:0] remx_reg, remy_reg;
    logic sgnx_reg, sgny_reg;

    logic        out_valid_reg, out_rep_reg, out_last_reg;
    logic [127:0] out_data_reg;

    logic cordic_start, cordic_done;
    logic [ANG_W-1:0] cordic_angle;
    logic signed [CRD_W-1:0] sin_q30, cos_q30;

    pvo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cordic_start),
        .angle   (cordic_angle),
        .done    (cordic_done),
        .sin_q30 (sin_q30),
        .cos_q30 (cos_q30)
    );

    assign cordic_start = (state_reg == S_HGO) || (state_reg == S_QGO);
    assign cordic_angle = (state_reg == S_QGO) ? (heading_reg >> 1) : heading_reg;

    // Signed partial product term; the sign bit of a two's complement
    // multiplier carries negative weight.
    function automatic logic signed [ACC_W-1:0] pick(input logic b,
                                                     input logic signed [ACC_W-1:0] v,
                                                     input logic neg);
        logic signed [ACC_W-1:0] t;
        t = b ? v : '0;
        return neg ? -t : t;
    endfunction

    function automatic logic signed [WV_W-1:0] round16(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-1:0] m;
        logic [ACC_W-1:0] q;
        m = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
        q = (m + ACC_W'(32768)) >> 16;
        return v[ACC_W-1] ? -WV_W'(q) : WV_W'(q);
    endfunction

    function automatic logic signed [QUAT_W-1:0] to_q15(input logic signed [CRD_W-1:0] v);
        logic [CRD_W-1:0] m;
        logic [CRD_W-1:0] q;
        logic signed [CRD_W-1:0] r;
        m = v[CRD_W-1] ? CRD_W'(-v) : CRD_W'(v);
        q = (m + CRD_W'(16384)) >> 15;
        r = v[CRD_W-1] ? -$signed(q) : $signed(q);
        if (r > 34'sd32767) r = 34'sd32767;
        if (r < -34'sd32768) r = -34'sd32768;
        return r[QUAT_W-1:0];
    endfunction

    function automatic logic signed [POS_W-1:0] sat_add(input logic signed [POS_W-1:0] p,
                                                        input logic [24:0] q,
                                                        input logic neg);
        logic signed [POS_W+2:0] s;
        logic signed [POS_W+2:0] d;
        d = $signed({10'd0, q});
        s = {{3{p[POS_W-1]}}, p} + (neg ? -d : d);
        if (s > 35'sd2147483647) s = 35'sd2147483647;
        if (s < -35'sd2147483648) s = -35'sd2147483648;
        return s[POS_W-1:0];
    endfunction

    // Restoring division step; the quotient bit shifts into the dividend.
    logic [30:0] trialx, trialy;
    logic        qbx, qby;
    assign trialx = {remx_reg, dvx_reg[PM_W-1]};
    assign trialy = {remy_reg, dvy_reg[PM_W-1]};
    assign qbx    = trialx >= {1'b0, POS_DIVISOR};
    assign qby    = trialy >= {1'b0, POS_DIVISOR};

    logic [TA_W-1:0] tmag;
    logic [ANG_W-1:0] hstep_next;
    logic signed [ACC_W-1:0] accx_next, accy_next;
    logic signed [WV_W-1:0] wx_next, wy_next;
    logic signed [PM_W-1:0] pacx_next, pacy_next;
    logic signed [TP_W-1:0] ptr_next;
    logic [PM_W-1:0] magx_next, magy_next;
    logic last_bit;

    always_comb begin
        last_bit  = (cnt_reg == 6'd15);
        accx_next = accx_reg + pick(vx_reg[0], mc_reg, last_bit)
                             - pick(vy_reg[0], ms_reg, last_bit);
        accy_next = accy_reg + pick(vx_reg[0], ms_reg, last_bit)
                             + pick(vy_reg[0], mc_reg, last_bit);
        wx_next   = round16(accx_reg);
        wy_next   = round16(accy_reg);
        pacx_next = pacx_reg;
        pacy_next = pacy_reg;
        ptr_next  = ptr_reg;
        if (us_reg[0]) begin
            pacx_next = pacx_reg + mwx_reg;
            pacy_next = pacy_reg + mwy_reg;
            ptr_next  = ptr_reg + mtr_reg;
        end
        magx_next = (pacx_next[PM_W-1] ? PM_W'(-pacx_next) : PM_W'(pacx_next))
                    + PM_W'(512000000);
        magy_next = (pacy_next[PM_W-1] ? PM_W'(-pacy_next) : PM_W'(pacy_next))
                    + PM_W'(512000000);
        tmag       = (acct_reg[TA_W-1] ? TA_W'(-acct_reg) : TA_W'(acct_reg))
                     + (TA_W'(1) << (TURN_SHIFT - 1));
        hstep_next = ANG_W'(tmag >> TURN_SHIFT);
        if (acct_reg[TA_W-1]) hstep_next = -hstep_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            pose_x_reg    <= '0;
            pose_y_reg    <= '0;
            heading_reg   <= '0;
            cnt_reg       <= '0;
            kind_reg      <= 1'b0;
            second_reg    <= 1'b0;
        end else begin
            if (out_valid_reg && m_tready) out_valid_reg <= 1'b0;
            if (cfg_valid) begin
                case (cfg_index)
                    REG_INIT_X:       pose_x_reg  <= cfg_data;
                    REG_INIT_Y:       pose_y_reg  <= cfg_data;
                    REG_INIT_HEADING: heading_reg <= cfg_data;
                    default: ;
                endcase
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        kind_reg   <= s_tuser[0];
                        second_reg <= 1'b0;
                        vx_reg     <= s_tdata[15:0];
                        vy_reg     <= s_tdata[31:16];
                        tr_reg     <= s_tdata[47:32];
                        us_reg     <= s_tdata[67:48];
                        state_reg  <= (s_tuser[0] == KIND_RESET) ? S_QGO : S_HGO;
                    end
                end
                S_HGO: state_reg <= S_HWAIT;
                S_HWAIT: begin
                    if (cordic_done) begin
                        mc_reg    <= ACC_W'(cos_q30);
                        ms_reg    <= ACC_W'(sin_q30);
                        accx_reg  <= '0;
                        accy_reg  <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_VMUL;
                    end
                end
                S_VMUL: begin
                    accx_reg <= accx_next;
                    accy_reg <= accy_next;
                    mc_reg   <= mc_reg <<< 1;
                    ms_reg   <= ms_reg <<< 1;
                    vx_reg   <= vx_reg >> 1;
                    vy_reg   <= vy_reg >> 1;
                    cnt_reg  <= cnt_reg + 1'b1;
                    if (last_bit) state_reg <= S_VRND;
                end
                S_VRND: begin
                    mwx_reg   <= PM_W'(wx_next);
                    mwy_reg   <= PM_W'(wy_next);
                    mtr_reg   <= TP_W'(tr_reg);
                    pacx_reg  <= '0;
                    pacy_reg  <= '0;
                    ptr_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= S_TMUL;
                end
                S_TMUL: begin
                    pacx_reg <= pacx_next;
                    pacy_reg <= pacy_next;
                    ptr_reg  <= ptr_next;
                    mwx_reg <= mwx_reg <<< 1;
                    mwy_reg <= mwy_reg <<< 1;
                    mtr_reg <= mtr_reg <<< 1;
                    us_reg  <= us_reg >> 1;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 6'(US_W - 1)) begin
                        cnt_reg   <= '0;
                        state_reg <= S_DIV;
                        dvx_reg   <= magx_next;
                        dvy_reg   <= magy_next;
                        sgnx_reg  <= pacx_next[PM_W-1];
                        sgny_reg  <= pacy_next[PM_W-1];
                        remx_reg  <= '0;
                        remy_reg  <= '0;
                        mt_reg    <= TA_W'(ptr_next);
                        kc_reg    <= TURN_SCALE;
                        acct_reg  <= '0;
                    end
                end
                S_DIV: begin
                    remx_reg <= qbx ? 30'(trialx - {1'b0, POS_DIVISOR}) : trialx[29:0];
                    remy_reg <= qby ? 30'(trialy - {1'b0, POS_DIVISOR}) : trialy[29:0];
                    dvx_reg  <= {dvx_reg[PM_W-2:0], qbx};
                    dvy_reg  <= {dvy_reg[PM_W-2:0], qby};
                    if (kc_reg[0]) acct_reg <= acct_reg + mt_reg;
                    mt_reg   <= mt_reg <<< 1;
                    kc_reg   <= kc_reg >> 1;
                    cnt_reg  <= cnt_reg + 1'b1;
                    if (cnt_reg == 6'(PM_W - 1)) state_reg <= S_UPD;
                end
                S_UPD: begin
                    pose_x_reg  <= sat_add(pose_x_reg, dvx_reg[24:0], sgnx_reg);
                    pose_y_reg  <= sat_add(pose_y_reg, dvy_reg[24:0], sgny_reg);
                    heading_reg <= heading_reg + hstep_next;
                    state_reg   <= S_QGO;
                end
                S_QGO: state_reg <= S_QWAIT;
                S_QWAIT: if (cordic_done) state_reg <= S_EMIT;
                S_EMIT: begin
                    if (!out_valid_reg || m_tready) begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {to_q15(cos_q30), to_q15(sin_q30), heading_reg,
                                          pose_y_reg, pose_x_reg};
                        out_rep_reg   <= (kind_reg == KIND_RESET) && !second_reg;
                        out_last_reg  <= (kind_reg != KIND_RESET) || second_reg;
                        if ((kind_reg == KIND_RESET) && !second_reg) begin
                            second_reg  <= 1'b1;
                            pose_x_reg  <= '0;
                            pose_y_reg  <= '0;
                            heading_reg <= '0;
                            state_reg   <= S_QGO;
                        end else begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_rep_reg;
    assign m_tlast   = out_last_reg;

endmodule

>>> hw/rtl/pvo_cordic.sv
// ----------------------------------------------------------------------------
// pvo_cordic: iterative rotation-mode CORDIC
// One micro-rotation per cycle; gives sine and cosine of a binary angle in Q1.30.
// ----------------------------------------------------------------------------
module pvo_cordic #(
    parameter int STEPS = 20
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [pvo_pkg::ANG_W-1:0]         angle,
    output logic                              done,
    output logic signed [pvo_pkg::CRD_W-1:0]  sin_q30,
    output logic signed [pvo_pkg::CRD_W-1:0]  cos_q30
);
    import pvo_pkg::*;

    localparam int N  = (STEPS > 32) ? 32 : STEPS;
    localparam int CW = $clog2(N);
    localparam logic signed [CRD_W-1:0] QTR  = 34'sh0_4000_0000;
    localparam logic signed [CRD_W-1:0] HALF = 34'sh0_8000_0000;

    logic                    busy_reg;
    logic                    done_reg;
    logic                    flip_reg;
    logic [CW-1:0]           cnt_reg;
    logic signed [CRD_W-1:0] x_reg, y_reg, z_reg;
    logic signed [CRD_W-1:0] z_start, xs, ys, at;

    assign xs = x_reg >>> cnt_reg;
    assign ys = y_reg >>> cnt_reg;
    assign at = CRD_W'(atan_turn(5'(cnt_reg)));
    assign z_start = {{(CRD_W-ANG_W){angle[ANG_W-1]}}, angle};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                x_reg    <= GAIN_Q30;
                y_reg    <= '0;
                // Fold the angle into the right half plane.
                if (z_start > QTR) begin
                    z_reg    <= z_start - HALF;
                    flip_reg <= 1'b1;
                end else if (z_start < -QTR) begin
                    z_reg    <= z_start + HALF;
                    flip_reg <= 1'b1;
                end else begin
                    z_reg    <= z_start;
                    flip_reg <= 1'b0;
                end
            end else if (busy_reg) begin
                if (z_reg >= 0) begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - at;
                end else begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + at;
                end
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(N - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done    = done_reg;
    assign sin_q30 = flip_reg ? -y_reg : y_reg;
    assign cos_q30 = flip_reg ? -x_reg : x_reg;

endmodule

>>> hw/rtl/pvo_checker.sv
// ----------------------------------------------------------------------------
// pvo_checker: port-level checks for the odometry block
// Watches the input and result stream ports over time.
// ----------------------------------------------------------------------------
module pvo_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata,
    input logic [0:0]   m_tuser,
    input logic         m_tlast
);

    // No result beat right after reset.
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result beat valid right after reset");

    // A stalled beat stays offered.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    // A stalled beat keeps its contents.
    a_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable({m_tdata, m_tuser, m_tlast}))
        else $error("result beat changed while stalled");

    // The pose report of a reset item is never the final beat.
    a_report_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> !m_tlast)
        else $error("reset report marked as last beat");

    // Only one item is in work at a time.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input beat taken while an item is in work");

endmodule

bind planar_velocity_odometry_unit pvo_checker u_pvo_checker (.*);
